FILE: design/adv_pkg.sv
// ----------------------------------------------------------------------------
// adv_pkg
// Shared types, codes and helpers for the authenticated decryption block:
// permutation state, command and status codes, byte masks and padding.
// ----------------------------------------------------------------------------
package adv_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [4:0] perm_state_t;

  typedef enum logic [1:0] {
    CMD_NONCE = 2'd0,
    CMD_AD    = 2'd1,
    CMD_CT    = 2'd2,
    CMD_TAG   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PLAIN    = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_ORDER    = 2'd3
  } status_t;

  localparam word_t       IV          = 64'h80800c0800000000;
  localparam logic [3:0]  ROUND_FULL  = 4'd0;
  localparam logic [3:0]  ROUND_DATA  = 4'd4;
  localparam logic [3:0]  ROUND_LAST  = 4'd11;
  localparam logic [4:0]  BLOCK_BYTES = 5'd16;
  localparam logic [4:0]  WORD_BYTES  = 5'd8;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  // first bytes of a big-endian word, byte i kept when base + i < n
  function automatic word_t byte_mask(input logic [4:0] n, input logic [4:0] base);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if ((base + 5'(i)) < n) m[63 - 8*i -: 8] = 8'hff;
    end
    return m;
  endfunction

  // pad byte at byte position n of a big-endian word
  function automatic word_t pad_at(input logic [2:0] n);
    word_t p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (n == 3'(i)) p[63 - 8*i -: 8] = PAD_BYTE;
    end
    return p;
  endfunction

endpackage

FILE: design/adv_round.sv
// ----------------------------------------------------------------------------
// adv_round
// One round of the 320-bit permutation: constant addition, s-box layer and
// linear diffusion layer, selected by the round number.
// ----------------------------------------------------------------------------
module adv_round (
  input  adv_pkg::perm_state_t x_in,
  input  logic [3:0]           rnd,
  output adv_pkg::perm_state_t x_out
);
  import adv_pkg::*;

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  word_t a0, a1, a2, a3, a4;
  word_t t0, t1, t2, t3, t4;
  word_t b0, b1, b2, b3, b4;

  always_comb begin
    a0 = x_in[0];
    a1 = x_in[1];
    a2 = x_in[2] ^ {56'd0, ~rnd, rnd};
    a3 = x_in[3];
    a4 = x_in[4];
    a0 = a0 ^ a4;
    a4 = a4 ^ a3;
    a2 = a2 ^ a1;
    t0 = ~a0 & a1;
    t1 = ~a1 & a2;
    t2 = ~a2 & a3;
    t3 = ~a3 & a4;
    t4 = ~a4 & a0;
    b0 = a0 ^ t1;
    b1 = a1 ^ t2;
    b2 = a2 ^ t3;
    b3 = a3 ^ t4;
    b4 = a4 ^ t0;
    b1 = b1 ^ b0;
    b0 = b0 ^ b4;
    b3 = b3 ^ b2;
    b2 = ~b2;
    x_out[0] = b0 ^ rotr(b0, 19) ^ rotr(b0, 28);
    x_out[1] = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
    x_out[2] = b2 ^ rotr(b2, 1) ^ rotr(b2, 6);
    x_out[3] = b3 ^ rotr(b3, 10) ^ rotr(b3, 17);
    x_out[4] = b4 ^ rotr(b4, 7) ^ rotr(b4, 41);
  end

endmodule

FILE: design/aead_decrypt_verify.sv
// ----------------------------------------------------------------------------
// aead_decrypt_verify
// Ascon-128a authenticated decryption of 128-bit blocks with tag check.
// ----------------------------------------------------------------------------
// A nonce transaction is accepted and then runs twelve permutation rounds,
// one round per cycle through the single round unit. A tag transaction also
// runs twelve rounds, then its verdict moves into the output register. An
// associated-data block or a full ciphertext block runs eight rounds. A final
// ciphertext block and an out-of-order transaction run no rounds.
// Results pass through a pending register and an output register, so a new
// transaction is taken while an earlier result waits on the master side; a
// pending result that cannot move on holds the slave side off until it can.
// The key is written through the cfg port; the user must do this only while
// the block is idle, since the block itself does not check for it.
module aead_decrypt_verify (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // data_high, data_low, byte_count, zero fill
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // plain_high, plain_low, plain_count, zero fill
  output logic [1:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);
  import adv_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} seq_t;
  typedef enum logic [1:0] {POST_NONE, POST_NONCE, POST_TAG} post_t;
  typedef enum logic [2:0] {
    PH_NONCE, PH_READY, PH_AD, PH_AD_DONE, PH_CT, PH_CT_DONE
  } phase_t;

  seq_t        st;
  post_t       post;
  phase_t      phase;
  logic [3:0]  rnd;
  perm_state_t x;
  perm_state_t y;
  word_t       key_high, key_low, tag_high, tag_low;

  logic        pend_valid;
  status_t     pend_status;
  word_t       pend_high, pend_low;
  logic [4:0]  pend_count;

  status_t     out_status;
  word_t       out_high, out_low;
  logic [4:0]  out_count;

  cmd_t        cmd;
  word_t       dh, dl, mh, ml, pad0, pad1;
  logic [4:0]  n;
  logic        ad_ok, ct_ok, tag_ok, accept, move_out;
  word_t       fin3, fin4;

  adv_round u_round (
    .x_in  (x),
    .rnd   (rnd),
    .x_out (y)
  );

  assign cmd       = cmd_t'(s_tuser);
  assign dh        = s_tdata[63:0];
  assign dl        = s_tdata[127:64];
  assign n         = s_tdata[132:128];
  assign s_tready  = (st == S_IDLE) && !pend_valid;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign move_out  = pend_valid && (!m_tvalid || m_tready);
  assign m_tuser   = out_status;
  assign m_tdata   = {3'd0, out_count, out_low, out_high};
  assign fin3      = y[3] ^ key_high;
  assign fin4      = y[4] ^ key_low;

  always_comb begin
    mh     = byte_mask(n, 5'd0);
    ml     = byte_mask(n, WORD_BYTES);
    pad0   = (n < WORD_BYTES) ? pad_at(n[2:0]) : '0;
    pad1   = (n >= WORD_BYTES && n < BLOCK_BYTES) ? pad_at(n[2:0]) : '0;
    ad_ok  = 1'b0;
    ct_ok  = 1'b0;
    tag_ok = 1'b0;
    unique case (phase)
      PH_READY:   begin ad_ok = 1'b1; ct_ok = 1'b1; end
      PH_AD:      ad_ok = 1'b1;
      PH_AD_DONE: ct_ok = 1'b1;
      PH_CT:      ct_ok = 1'b1;
      PH_CT_DONE: tag_ok = 1'b1;
      default:    ;
    endcase
    if (n > BLOCK_BYTES) begin
      ad_ok = 1'b0;
      ct_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      if (cfg_index) key_low <= cfg_data;
      else key_high <= cfg_data;
    end

    if (move_out) begin
      out_status <= pend_status;
      out_high   <= pend_high;
      out_low    <= pend_low;
      out_count  <= pend_count;
    end

    unique case (st)
      S_IDLE: begin
        if (accept) begin
          pend_high   <= '0;
          pend_low    <= '0;
          pend_count  <= '0;
          pend_status <= ST_ORDER;
          unique case (cmd)
            CMD_NONCE: begin
              x     <= {dl, dh, key_low, key_high, IV};
              rnd   <= ROUND_FULL;
              post  <= POST_NONCE;
              st    <= S_RUN;
              phase <= PH_READY;
            end
            CMD_AD: begin
              if (ad_ok) begin
                x[0]  <= x[0] ^ (dh & mh) ^ pad0;
                x[1]  <= x[1] ^ (dl & ml) ^ pad1;
                rnd   <= ROUND_DATA;
                post  <= POST_NONE;
                st    <= S_RUN;
                phase <= (n < BLOCK_BYTES) ? PH_AD_DONE : PH_AD;
              end else begin
                pend_valid <= 1'b1;
              end
            end
            CMD_CT: begin
              pend_valid <= 1'b1;
              if (ct_ok) begin
                pend_status <= ST_PLAIN;
                pend_high   <= (x[0] ^ dh) & mh;
                pend_low    <= (x[1] ^ dl) & ml;
                pend_count  <= n;
                x[0] <= ((x[0] & ~mh) | (dh & mh)) ^ pad0;
                x[1] <= ((x[1] & ~ml) | (dl & ml)) ^ pad1;
                x[4] <= x[4] ^ {63'd0, phase != PH_CT};
                rnd  <= ROUND_DATA;
                post <= POST_NONE;
                if (n < BLOCK_BYTES) begin
                  phase <= PH_CT_DONE;
                end else begin
                  phase <= PH_CT;
                  st    <= S_RUN;
                end
              end
            end
            CMD_TAG: begin
              if (tag_ok) begin
                x[2]     <= x[2] ^ key_high;
                x[3]     <= x[3] ^ key_low;
                tag_high <= dh;
                tag_low  <= dl;
                rnd      <= ROUND_FULL;
                post     <= POST_TAG;
                st       <= S_RUN;
                phase    <= PH_NONCE;
              end else begin
                pend_valid <= 1'b1;
              end
            end
            default: ;
          endcase
        end else if (move_out) begin
          pend_valid <= 1'b0;
        end
      end
      S_RUN: begin
        if (move_out) pend_valid <= 1'b0;
        x   <= y;
        rnd <= rnd + 4'd1;
        if (rnd == ROUND_LAST) begin
          st  <= S_IDLE;
          rnd <= '0;
          if (post != POST_NONE) begin
            x[3] <= fin3;
            x[4] <= fin4;
          end
          if (post == POST_TAG) begin
            pend_valid  <= 1'b1;
            pend_high   <= '0;
            pend_low    <= '0;
            pend_count  <= '0;
            pend_status <= (((fin3 ^ tag_high) | (fin4 ^ tag_low)) == '0)
                           ? ST_MATCH : ST_MISMATCH;
          end
        end
      end
      default: st <= S_IDLE;
    endcase

    if (move_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;

    if (rst) begin
      st         <= S_IDLE;
      post       <= POST_NONE;
      phase      <= PH_NONCE;
      rnd        <= '0;
      x          <= '0;
      key_high   <= '0;
      key_low    <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    st == S_RUN |-> rnd <= ROUND_LAST)
    else $error("round counter past last round");

  a_nonce_starts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_NONCE |=> st == S_RUN && rnd == ROUND_FULL && phase == PH_READY)
    else $error("nonce did not start initialization");

  a_tag_phase: assert property (@(posedge clk) disable iff (rst)
    pend_valid && (pend_status == ST_MATCH || pend_status == ST_MISMATCH)
      |-> phase == PH_NONCE)
    else $error("tag result without return to nonce phase");

  a_clean_status: assert property (@(posedge clk) disable iff (rst)
    pend_valid && pend_status != ST_PLAIN
      |-> pend_high == '0 && pend_low == '0 && pend_count == '0)
    else $error("status result carries data");

endmodule
